// ----- hdl/kda_pkg.sv -----
// ----------------------------------------------------------------------------
// kda_pkg: shared types and constants for the keypad debounce block
// Key count, timer width, register map, phase encoding and config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kda_pkg;

  localparam int NUM_KEYS   = 6;
  localparam int TIMER_BITS = 16;
  localparam int KEY_IDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CODE_W     = 3;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // APB register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd150;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_REPEAT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] repeat_delay_ticks;
    logic [CFG_W-1:0] repeat_interval_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/keypad_debounce_autorepeat.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat: key debounce with typematic auto repeat
// Scans six active-high keys once per tick and reports presses and repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / keys_pressed): one transfer is one
//   millisecond tick carrying the pressed state of every key, bit 0 has the
//   highest priority.
//   Output channel (out_valid / out_stall / key_code / repeat_event): exactly
//   one result transfer per tick. key_code 0 means no event, otherwise it is
//   the key index plus one; repeat_event marks an auto repeat.
//   APB port: debounce, repeat delay and repeat interval in ticks, at byte
//   addresses 0x0, 0x4, 0x8. Write only while no tick is in flight.
//   Path: an accepted tick goes through the input register, then the result
//   register. Throughput: one tick per cycle unless out_stall holds the flow;
//   the single state update (priority encoder plus one counter compare) sets it.
//   Reset (rst, synchronous): timing registers return to 50/1000/150, the
//   scanner goes idle, both pipeline registers empty.
//   Stalls: with out_stall high the result holds; one more tick still enters
//   the input register, after which in_stall rises until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_autorepeat (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [kda_pkg::NUM_KEYS-1:0] keys_pressed,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [kda_pkg::CODE_W-1:0]   key_code,
  output logic                              repeat_event,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [kda_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kda_pkg::DATA_W-1:0]   pwdata,
  output logic      [kda_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);
  import kda_pkg::*;

  cfg_t                cfg;

  // input register
  logic                in_full;
  logic [NUM_KEYS-1:0] keys_q;

  // the tick in the input register is processed when the result slot frees up
  logic                advance;
  logic                in_take;
  logic [CODE_W-1:0]   code_c;
  logic                rep_c;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  kda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kda_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .keys         (keys_q),
    .cfg          (cfg),
    .key_code     (code_c),
    .repeat_event (rep_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      keys_q <= keys_pressed;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_code     <= code_c;
      repeat_event <= rep_c;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/kda_regs.sv -----
// ----------------------------------------------------------------------------
// kda_regs: APB configuration registers
// Three 16-bit timing registers, writable and readable over APB.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [kda_pkg::ADDR_W-1:0] paddr,
  input  wire logic [kda_pkg::DATA_W-1:0] pwdata,
  output logic      [kda_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output kda_pkg::cfg_t                   cfg
);
  import kda_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks        <= DEBOUNCE_RST;
      cfg.repeat_delay_ticks    <= DELAY_RST;
      cfg.repeat_interval_ticks <= INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE: cfg.debounce_ticks        <= pwdata[CFG_W-1:0];
        REG_DELAY:    cfg.repeat_delay_ticks    <= pwdata[CFG_W-1:0];
        REG_INTERVAL: cfg.repeat_interval_ticks <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(cfg.debounce_ticks);
      REG_DELAY:    prdata = DATA_W'(cfg.repeat_delay_ticks);
      REG_INTERVAL: prdata = DATA_W'(cfg.repeat_interval_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/kda_core.sv -----
// ----------------------------------------------------------------------------
// kda_core: debounce and auto-repeat state machine
// Advances one tick per step; result fields are combinational from state and inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [kda_pkg::NUM_KEYS-1:0] keys,
  input  wire kda_pkg::cfg_t                cfg,
  output logic      [kda_pkg::CODE_W-1:0]   key_code,
  output logic                              repeat_event
);
  import kda_pkg::*;

  phase_t                phase, phase_next;
  logic [KEY_IDX_W-1:0]  active_key, active_key_next;
  logic [TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;

  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]      inc_ext;
  logic                  active_down;
  logic                  any_down;
  logic [KEY_IDX_W-1:0]  scan_idx;
  logic                  deb_done, delay_done, interval_done, deb_zero;
  logic [CODE_W-1:0]     active_code, scan_code;

  // saturating tick counter
  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign inc_ext     = CMP_W'(elapsed_inc);

  assign deb_done      = inc_ext >= CMP_W'(cfg.debounce_ticks);
  assign delay_done    = inc_ext >= CMP_W'(cfg.repeat_delay_ticks);
  assign interval_done = inc_ext >= CMP_W'(cfg.repeat_interval_ticks);
  assign deb_zero      = (cfg.debounce_ticks == '0);

  assign active_down = (32'(active_key) < NUM_KEYS) && keys[active_key];

  // priority encoder, bit 0 wins
  always_comb begin
    any_down = 1'b0;
    scan_idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (keys[i]) begin
        any_down = 1'b1;
        scan_idx = KEY_IDX_W'(i);
      end
    end
  end

  assign active_code = CODE_W'(active_key) + 1'b1;
  assign scan_code   = CODE_W'(scan_idx) + 1'b1;

  // next state
  always_comb begin
    phase_next         = phase;
    active_key_next    = active_key;
    elapsed_ticks_next = elapsed_ticks;
    if ((phase == PH_HELD || phase == PH_REPEAT) && active_down) begin
      elapsed_ticks_next = elapsed_inc;
      if (phase == PH_HELD && delay_done) begin
        phase_next         = PH_REPEAT;
        elapsed_ticks_next = '0;
      end else if (phase == PH_REPEAT && interval_done) begin
        elapsed_ticks_next = '0;
      end
    end else if (phase == PH_DEBOUNCE) begin
      elapsed_ticks_next = elapsed_inc;
      if (deb_done) begin
        phase_next = active_down ? PH_HELD : PH_IDLE;
      end
    end else if (any_down) begin
      // idle, or the held key was released: rescan this tick
      active_key_next    = scan_idx;
      elapsed_ticks_next = '0;
      phase_next         = deb_zero ? PH_HELD : PH_DEBOUNCE;
    end else begin
      phase_next = PH_IDLE;
    end
  end

  // outputs
  always_comb begin
    key_code     = '0;
    repeat_event = 1'b0;
    if ((phase == PH_HELD || phase == PH_REPEAT) && active_down) begin
      if ((phase == PH_HELD && delay_done) || (phase == PH_REPEAT && interval_done)) begin
        key_code     = active_code;
        repeat_event = 1'b1;
      end
    end else if (phase == PH_DEBOUNCE) begin
      if (deb_done && active_down) begin
        key_code = active_code;
      end
    end else if (any_down && deb_zero) begin
      key_code = scan_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      active_key    <= '0;
      elapsed_ticks <= '0;
    end else if (step) begin
      phase         <= phase_next;
      active_key    <= active_key_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

`default_nettype wire
